// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, off while reset is held
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also runs during reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned PAY_W         = 16;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned OCC_W         = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic              ins;
    logic              ext;
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none

module spq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spq_pkg::cell_cmd_t cmd_i,
  input  wire spq_pkg::entry_t   prev_i,
  input  wire logic              prev_beyond_i,
  input  wire spq_pkg::entry_t   next_i,
  output spq_pkg::entry_t        entry_o,
  output logic                   beyond_o
);

  logic                       valid_q, valid_d;
  logic [spq_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [spq_pkg::PAY_W-1:0]  pay_q, pay_d;

  // this cell sits at or past the landing point of the new entry
  assign beyond_o = !valid_q || (prio_q <= cmd_i.prio);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    pay_d   = pay_q;
    if (cmd_i.ins) begin
      if (beyond_o && prev_beyond_i) begin
        valid_d = prev_i.valid;
        prio_d  = prev_i.prio;
        pay_d   = prev_i.payload;
      end else if (beyond_o) begin
        valid_d = 1'b1;
        prio_d  = cmd_i.prio;
        pay_d   = cmd_i.payload;
      end
    end else if (cmd_i.ext) begin
      valid_d = next_i.valid;
      prio_d  = next_i.prio;
      pay_d   = next_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    pay_q  <= pay_d;
  end

  assign entry_o = '{valid: valid_q, prio: prio_q, payload: pay_q};

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue_top.sv =====
`default_nettype none

// Bounded max-priority queue built as a row of DEPTH cells, highest entry in
// cell 0. Busy stays low, so an item may be started in any cycle, and its
// result appears on the result ports with done_o high in the cycle after the
// item is taken. The receiver cannot stall; the result fields hold until the
// next item is taken. An insert compares the new
// priority against every cell at once and the cells move aside in the same
// cycle; the compare across the row and the rank encoder that follows it set
// the clock period. An extract shifts the row one cell towards the top.

module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]  priority_req_i,
  input  wire logic [spq_pkg::PAY_W-1:0]   payload_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [spq_pkg::CAP_W-1:0]   cfg_data_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [spq_pkg::PRIO_W-1:0]       out_priority_o,
  output logic [spq_pkg::PAY_W-1:0]        out_payload_o,
  output logic [spq_pkg::SLOT_W-1:0]       insert_slot_o,
  output logic [spq_pkg::OCC_W-1:0]        occupancy_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OW    = (CNT_W > spq_pkg::OCC_W) ? CNT_W : spq_pkg::OCC_W;
  localparam int unsigned RW    = (CNT_W > spq_pkg::SLOT_W) ? CNT_W : spq_pkg::SLOT_W;

  spq_pkg::entry_t    entry_w [DEPTH];
  logic [DEPTH-1:0]   beyond_w;
  logic [DEPTH-1:0]   first_w;
  spq_pkg::cell_cmd_t cmd;

  logic [CNT_W-1:0]         count_q, count_d;
  logic [spq_pkg::CAP_W-1:0] cap_q;

  logic                        done_q;
  spq_pkg::status_e            status_q, status_d;
  logic [spq_pkg::PRIO_W-1:0]  opri_q, opri_d;
  logic [spq_pkg::PAY_W-1:0]   opay_q, opay_d;
  logic [spq_pkg::SLOT_W-1:0]  slot_q, slot_d;

  logic             accept, full, empty;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] rank;
  logic [RW-1:0]    rank_w;
  logic [OW-1:0]    count_ext;
  logic [OW-1:0]    occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_pkg::entry_t prev_e, next_e;
      logic            prev_b;
      if (gi == 0) begin : g_head
        assign prev_e   = '0;
        assign prev_b   = 1'b0;
        assign first_w[gi] = beyond_w[gi];
      end else begin : g_body
        assign prev_e   = entry_w[gi-1];
        assign prev_b   = beyond_w[gi-1];
        assign first_w[gi] = beyond_w[gi] && !beyond_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_link
        assign next_e = entry_w[gi+1];
      end
      spq_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .prev_i        (prev_e),
        .prev_beyond_i (prev_b),
        .next_i        (next_e),
        .entry_o       (entry_w[gi]),
        .beyond_o      (beyond_w[gi])
      );
    end
  endgenerate

  // cell index where the new entry lands, counted from the top
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_w[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign rank      = count_q - CNT_W'(pos);
  assign rank_w    = RW'(rank);
  assign count_ext = OW'(count_q);
  assign full      = (count_ext >= OW'(cap_q)) || (count_q >= CNT_W'(DEPTH));
  assign empty     = (count_q == '0);

  always_comb begin
    cmd.ins     = accept && (operation_i == spq_pkg::OP_INSERT) && !full;
    cmd.ext     = accept && (operation_i == spq_pkg::OP_EXTRACT) && !empty;
    cmd.prio    = priority_req_i;
    cmd.payload = payload_i;

    count_d  = count_q;
    status_d = status_q;
    opri_d   = opri_q;
    opay_d   = opay_q;
    slot_d   = slot_q;

    if (accept) begin
      opri_d = '0;
      opay_d = '0;
      slot_d = '0;
      if (operation_i == spq_pkg::OP_INSERT) begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          status_d = spq_pkg::ST_INSERTED;
          slot_d   = rank_w[spq_pkg::SLOT_W-1:0];
          count_d  = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          status_d = spq_pkg::ST_EXTRACTED;
          opri_d   = entry_w[0].prio;
          opay_d   = entry_w[0].payload;
          count_d  = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= spq_pkg::CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    opri_q   <= opri_d;
    opay_q   <= opay_d;
    slot_q   <= slot_d;
  end

  assign occ_ext        = OW'(count_q);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = opri_q;
  assign out_payload_o  = opay_q;
  assign insert_slot_o  = slot_q;
  assign occupancy_o    = occ_ext[spq_pkg::OCC_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module spq_port_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done_o,
  input wire logic [1:0]                 status_o,
  input wire logic [spq_pkg::PRIO_W-1:0] out_priority_o,
  input wire logic [spq_pkg::PAY_W-1:0]  out_payload_o,
  input wire logic [spq_pkg::SLOT_W-1:0] insert_slot_o,
  input wire logic [spq_pkg::OCC_W-1:0]  occupancy_o
);

  logic taken;
  logic rejected;
  logic data_zero;
  logic empty_res;

  assign taken     = start && !busy;
  assign rejected  = done_o && (status_o == spq_pkg::ST_FULL || status_o == spq_pkg::ST_EMPTY);
  assign data_zero = (out_priority_o == '0) && (out_payload_o == '0) && (insert_slot_o == '0);
  assign empty_res = done_o && (status_o == spq_pkg::ST_EMPTY);

  // every item taken gives a result in the next cycle
  `SPQ_ASSERT(a_result_follows, clk_i, rst_ni, taken |=> done_o, "item without result")

  // no result without an item taken the cycle before
  `SPQ_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(taken), "result without item")

  // rejected items carry zero data fields
  `SPQ_ASSERT(a_reject_zero, clk_i, rst_ni, rejected |-> data_zero, "rejected item with data")

  // an empty extract means nothing is held
  `SPQ_ASSERT(a_empty_occ, clk_i, rst_ni, empty_res |-> occupancy_o == '0, "empty with entries held")

endmodule

bind sorted_priority_queue_top spq_port_checker u_spq_checker (.*);

`default_nettype wire
